// File: rtl/core/vtp_pkg.sv
// Shared types and constants for the vertex transform block.
// No dependencies.
`timescale 1ns / 1ps
package vtp_pkg;
	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS  = 8;
	localparam int IDX_W     = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	// Dividend width: 32-bit value shifted by FRAC_BITS, magnitude form.
	localparam int DIVN_W    = 32 + FRAC_BITS;
	localparam int PROD_W    = 64;
	localparam int SUM_W     = 66;

	typedef enum logic [IDX_W-1:0] {
		REG_R0C01 = 3'd0, REG_R0C23 = 3'd1, REG_R1C01 = 3'd2, REG_R1C23 = 3'd3,
		REG_R2C01 = 3'd4, REG_R2C23 = 3'd5, REG_R3C01 = 3'd6, REG_R3C23 = 3'd7
	} reg_idx_t;

	// Item handed from the transform front to the divide back.
	typedef struct packed {
		logic              func;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic              sat;
	} xf_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic              w_zero;
		logic              saturated;
	} res_item_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v,
	                                             output logic s);
		logic signed [SUM_W-1:0] mx;
		logic signed [SUM_W-1:0] mn;
		mx = SUM_W'(64'sh7FFF_FFFF);
		mn = -SUM_W'(64'sh8000_0000);
		s = 1'b0;
		if (v > mx) begin
			s = 1'b1;
			return 32'sh7FFF_FFFF;
		end else if (v < mn) begin
			s = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction
endpackage

// File: rtl/core/vtp_front.sv
// Front part: matrix registers and pipelined 4x4 dot products with floor and saturation.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_func,
	input  logic [127:0]         in_vec,
	input  logic                 adv,
	output logic                 out_valid,
	output vtp_pkg::xf_item_t    out_item
);
	logic [63:0] regs_q [vtp_pkg::NUM_REGS];
	logic signed [31:0] m [4][4];
	logic signed [31:0] v [4];

	logic v_s1, v_s2, v_s3;
	logic f_s1, f_s2;
	logic signed [vtp_pkg::PROD_W-1:0] p_s1 [4][4];
	logic signed [vtp_pkg::SUM_W-1:0] s_s2 [4];
	vtp_pkg::xf_item_t it_s3;
	vtp_pkg::xf_item_t nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= 64'd65536;
			regs_q[1] <= 64'd0;
			regs_q[2] <= 64'd65536 << 32;
			regs_q[3] <= 64'd0;
			regs_q[4] <= 64'd0;
			regs_q[5] <= 64'd65536;
			regs_q[6] <= 64'd0;
			regs_q[7] <= 64'd65536 << 32;
		end else if (cfg_valid) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			m[r][0] = regs_q[2*r][31:0];
			m[r][1] = regs_q[2*r][63:32];
			m[r][2] = regs_q[2*r+1][31:0];
			m[r][3] = regs_q[2*r+1][63:32];
			v[r]    = in_vec[32*r +: 32];
		end
	end

	// Floor of the exact sum equals the exact sum shifted right arithmetically.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1 <= in_func;
			f_s2 <= f_s1;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					p_s1[r][c] <= m[r][c] * v[c];
				end
				s_s2[r] <= (vtp_pkg::SUM_W'(p_s1[r][0]) + vtp_pkg::SUM_W'(p_s1[r][1])
				          + vtp_pkg::SUM_W'(p_s1[r][2]) + vtp_pkg::SUM_W'(p_s1[r][3]))
				          >>> vtp_pkg::FRAC_BITS;
			end
			it_s3 <= nx;
		end
	end

	always_comb begin
		logic s0, s1, s2, s3;
		nx.func = f_s2;
		nx.x = vtp_pkg::sat32(s_s2[0], s0);
		nx.y = vtp_pkg::sat32(s_s2[1], s1);
		nx.z = vtp_pkg::sat32(s_s2[2], s2);
		nx.w = vtp_pkg::sat32(s_s2[3], s3);
		nx.sat = s0 | s1 | s2 | s3;
	end

	assign out_valid = v_s3;
	assign out_item  = it_s3;
endmodule

// File: rtl/core/vtp_queue.sv
// Short queue between the transform front and the divide back.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vtp_pkg::xf_item_t push_item,
	input  logic              pop,
	output logic              not_empty,
	output logic              almost_full,
	output vtp_pkg::xf_item_t head
);
	vtp_pkg::xf_item_t mem_q [vtp_pkg::QDEPTH];
	logic [vtp_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [vtp_pkg::QPTR_W:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (vtp_pkg::QPTR_W+1)'(push) - (vtp_pkg::QPTR_W+1)'(pop);
		end
	end

	assign not_empty   = (cnt_q != '0);
	assign almost_full = (cnt_q >= (vtp_pkg::QPTR_W+1)'(vtp_pkg::QDEPTH - 1));
	assign head        = mem_q[rp_q];
endmodule

// File: rtl/core/vtp_div.sv
// Back part: pipelined restoring divider, one quotient bit per stage, three lanes.
// Depends on vtp_pkg.
`timescale 1ns / 1ps
module vtp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  vtp_pkg::xf_item_t  in_item,
	output logic               out_valid,
	output vtp_pkg::res_item_t out_item
);
	localparam int NS = vtp_pkg::DIVN_W;
	localparam int RW = 33;

	logic               vld_q [NS+1];
	vtp_pkg::xf_item_t  it_q  [NS+1];
	logic               dv_q  [NS+1];
	logic [RW-1:0]      den_q [NS+1];
	logic [NS-1:0]      n_q   [NS+1][3];
	logic [RW-1:0]      r_q   [NS+1][3];
	logic               ng_q  [NS+1][3];
	vtp_pkg::res_item_t res_q;
	logic               rv_q;

	logic [31:0] wmag;
	always_comb begin
		wmag = in_item.w[31] ? 32'(-in_item.w) : 32'(in_item.w);
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] c;
		logic [31:0] cm;
		logic [RW:0] t;
		if (adv) begin
			it_q[0]  <= in_item;
			dv_q[0]  <= in_item.func && (in_item.w != 0);
			den_q[0] <= {1'b0, wmag};
			for (int k = 0; k < 3; k++) begin
				c = (k == 0) ? in_item.x : (k == 1) ? in_item.y : in_item.z;
				cm = c[31] ? 32'(-c) : 32'(c);
				n_q[0][k]  <= {cm, {vtp_pkg::FRAC_BITS{1'b0}}};
				r_q[0][k]  <= '0;
				ng_q[0][k] <= c[31] ^ in_item.w[31];
			end
			for (int s = 0; s < NS; s++) begin
				it_q[s+1]  <= it_q[s];
				dv_q[s+1]  <= dv_q[s];
				den_q[s+1] <= den_q[s];
				for (int k = 0; k < 3; k++) begin
					t = {r_q[s][k], n_q[s][k][NS-1]};
					ng_q[s+1][k] <= ng_q[s][k];
					if (t >= {1'b0, den_q[s]}) begin
						r_q[s+1][k] <= RW'(t - {1'b0, den_q[s]});
						n_q[s+1][k] <= {n_q[s][k][NS-2:0], 1'b1};
					end else begin
						r_q[s+1][k] <= RW'(t);
						n_q[s+1][k] <= {n_q[s][k][NS-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= NS; s++) vld_q[s] <= 1'b0;
			rv_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int s = 0; s < NS; s++) vld_q[s+1] <= vld_q[s];
			rv_q <= vld_q[NS];
		end
	end

	// Quotient sign and clamp, then register the result.
	always_ff @(posedge clk) begin
		logic [NS-1:0] qm;
		logic [31:0] o [3];
		logic sat;
		if (adv) begin
			sat = it_q[NS].sat;
			for (int k = 0; k < 3; k++) begin
				qm = n_q[NS][k];
				o[k] = (k == 0) ? it_q[NS].x : (k == 1) ? it_q[NS].y : it_q[NS].z;
				if (dv_q[NS]) begin
					if (!ng_q[NS][k]) begin
						if (qm > NS'(32'h7FFF_FFFF)) begin
							o[k] = 32'h7FFF_FFFF;
							sat = 1'b1;
						end else begin
							o[k] = qm[31:0];
						end
					end else begin
						if (qm > NS'(33'h8000_0000)) begin
							o[k] = 32'h8000_0000;
							sat = 1'b1;
						end else begin
							o[k] = 32'(-qm[31:0]);
						end
					end
				end
			end
			res_q.x <= o[0];
			res_q.y <= o[1];
			res_q.z <= o[2];
			res_q.w <= it_q[NS].w;
			res_q.w_zero <= (it_q[NS].w == 0);
			res_q.saturated <= sat;
		end
	end

	assign out_valid = rv_q;
	assign out_item  = res_q;
endmodule

// File: rtl/core/vertex_transform_project.sv
// Top level: 4x4 matrix transform with optional perspective divide.
// Depends on vtp_pkg, vtp_front, vtp_queue, vtp_div.
//
// channel   | dir | handshake             | payload
// s_axis    | in  | s_axis_tvalid/tready  | tdata: in_x,in_y,in_z,in_w; tuser: func
// m_axis    | out | m_axis_tvalid/tready  | tdata: out_x..out_w; tuser: w_zero,saturated
// cfg       | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One vertex per cycle while m_axis_tready is high; a vertex passes 3 front stages, 1 in
// the queue, the divider input register, 48 quotient-bit stages and its output register.
// Reset clears all valid bits and loads the identity matrix.
// A queue holding three beats stalls the front; an output stall freezes the divide pipe.
`timescale 1ns / 1ps
module vertex_transform_project (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // in_x, in_y, in_z, in_w
	input  logic         s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // out_x, out_y, out_z, out_w
	output logic [1:0]   m_axis_tuser,  // w_zero, saturated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	logic f_valid, q_ne, q_af, b_adv, b_valid, f_adv;
	vtp_pkg::xf_item_t f_item, q_head;
	vtp_pkg::res_item_t b_item;

	// Front holds up to 3 in flight; stall it once the queue is nearly full.
	assign f_adv = !q_af;
	assign s_axis_tready = f_adv;
	assign cfg_ready = 1'b1;

	vtp_front u_front (
		.clk, .arst_n, .cfg_valid, .cfg_index, .cfg_data,
		.in_valid(s_axis_tvalid), .in_func(s_axis_tuser), .in_vec(s_axis_tdata),
		.adv(f_adv), .out_valid(f_valid), .out_item(f_item)
	);

	assign b_adv = !b_valid || m_axis_tready;

	vtp_queue u_queue (
		.clk, .arst_n, .push(f_valid && f_adv), .push_item(f_item),
		.pop(q_ne && b_adv), .not_empty(q_ne), .almost_full(q_af), .head(q_head)
	);

	vtp_div u_div (
		.clk, .arst_n, .adv(b_adv), .in_valid(q_ne), .in_item(q_head),
		.out_valid(b_valid), .out_item(b_item)
	);

	assign m_axis_tvalid = b_valid;
	assign m_axis_tdata  = {b_item.w, b_item.z, b_item.y, b_item.x};
	assign m_axis_tuser  = {b_item.saturated, b_item.w_zero};
endmodule

// File: rtl/core/vtp_checker.sv
// Port-level checks for the vertex transform block, bound to the top level.
// Depends on vertex_transform_project ports only.
`timescale 1ns / 1ps
module vtp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser,
	input logic         cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped under stall");
	a_wz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0] == (m_axis_tdata[127:96] == 32'd0))
		else $error("w_zero disagrees with out_w");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (.*);

// File: test/vertex_transform_project_test.sv
// Testbench for vertex_transform_project: stream driver and monitor with a
// scoreboard of predicted transformed vertices. Depends on vtp_pkg and the RTL.
`timescale 1ns / 1ps
module vertex_transform_project_test;
	typedef struct {
		logic               func;
		logic signed [31:0] v [4];
	} vertex_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [127:0]         s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [127:0]         m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	vtp_pkg::reg_idx_t    cfg_index;
	logic [63:0]          cfg_data;

	// stall mode: 0 none, 1 sender idle, 2 receiver stalls, 3 both
	int                   stall_mode;
	int                   errors;
	vertex_t              pending_vertices [$];
	vtp_pkg::res_item_t   expected_vertices [$];
	logic signed [31:0]   matrix [4][4];

	vertex_transform_project dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic bit idle_now(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [65:0] v, ref logic s);
		if (v > 66'sh7FFF_FFFF) begin
			s = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -66'sh8000_0000) begin
			s = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic vtp_pkg::res_item_t transform_vertex(vertex_t vx);
		vtp_pkg::res_item_t r;
		logic signed [65:0] acc;
		logic signed [65:0] a;
		logic signed [65:0] b;
		logic signed [31:0] c [4];
		longint             num;
		logic               s;
		s = 1'b0;
		for (int i = 0; i < 4; i++) begin
			acc = '0;
			for (int j = 0; j < 4; j++) begin
				a = matrix[i][j];
				b = vx.v[j];
				acc += a * b;
			end
			c[i] = clamp32(acc >>> vtp_pkg::FRAC_BITS, s);
		end
		r.w_zero = (c[3] == 0);
		if (vx.func && !r.w_zero)
			for (int i = 0; i < 3; i++) begin
				num = longint'(c[i]) * (longint'(1) << vtp_pkg::FRAC_BITS);
				c[i] = clamp32(66'(num / longint'(c[3])), s);
			end
		r.x = c[0];
		r.y = c[1];
		r.z = c[2];
		r.w = c[3];
		r.saturated = s;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			vertex_t vx;
			if (s_axis_tvalid && s_axis_tready) begin
				vx.func = s_axis_tuser;
				for (int k = 0; k < 4; k++) vx.v[k] = s_axis_tdata[32*k +: 32];
				expected_vertices.push_back(transform_vertex(vx));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_vertices.size() != 0 &&
				    !((stall_mode == 1 && idle_now(81)) || (stall_mode == 3 && idle_now(16)))) begin
					vx = pending_vertices.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= vx.func;
					s_axis_tdata  <= {vx.v[3], vx.v[2], vx.v[1], vx.v[0]};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			vtp_pkg::res_item_t e;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_vertices.size() == 0) begin
					report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'h0);
				end else begin
					e = expected_vertices.pop_front();
					if (m_axis_tdata[31:0] !== e.x)    report_mismatch("out_x", m_axis_tdata[31:0], e.x);
					if (m_axis_tdata[63:32] !== e.y)   report_mismatch("out_y", m_axis_tdata[63:32], e.y);
					if (m_axis_tdata[95:64] !== e.z)   report_mismatch("out_z", m_axis_tdata[95:64], e.z);
					if (m_axis_tdata[127:96] !== e.w)  report_mismatch("out_w", m_axis_tdata[127:96], e.w);
					if (m_axis_tuser[0] !== e.w_zero)
						report_mismatch("w_zero", 32'(m_axis_tuser[0]), 32'(e.w_zero));
					if (m_axis_tuser[1] !== e.saturated)
						report_mismatch("saturated", 32'(m_axis_tuser[1]), 32'(e.saturated));
				end
			end
			m_axis_tready <= !((stall_mode == 2 && idle_now(81)) ||
			                   (stall_mode == 3 && idle_now(16)));
		end
	end

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(3, 0))
			0: return $urandom();
			1: return 32'($urandom_range(32'h3FFFF, 0)) - 32'h20000;
			2: begin
				case ($urandom_range(4, 0))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					3: return 32'h0001_0000;
					default: return 32'h0;
				endcase
			end
			default: return 32'($urandom_range(32'hFFFFFF, 0)) - 32'h800000;
		endcase
	endfunction

	function automatic logic [31:0] pick_entry(int flavor);
		case (flavor)
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			4: return $urandom();
			default: return pick_coord();
		endcase
	endfunction

	task automatic add_vertex(logic func, logic [31:0] x, logic [31:0] y,
	                          logic [31:0] z, logic [31:0] w);
		vertex_t vx;
		vx.func = func;
		vx.v[0] = x;
		vx.v[1] = y;
		vx.v[2] = z;
		vx.v[3] = w;
		pending_vertices.push_back(vx);
	endtask

	task automatic write_reg(int idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= vtp_pkg::reg_idx_t'(idx);
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		matrix[idx/2][(idx%2)*2]     = val[31:0];
		matrix[idx/2][(idx%2)*2 + 1] = val[63:32];
	endtask

	task automatic drain();
		while (pending_vertices.size() != 0 || s_axis_tvalid || expected_vertices.size() != 0)
			@(posedge clk);
		// let the pipe settle before touching the matrix
		repeat (80) @(posedge clk);
	endtask

	initial begin
		int flavor;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = vtp_pkg::REG_R0C01;
		cfg_data      = '0;
		stall_mode    = 0;
		errors        = 0;
		// identity after reset
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) matrix[i][j] = (i == j) ? 32'h0001_0000 : 32'h0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: identity matrix
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(1, 0, 0, 0, 0);
		add_vertex(1, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'h0);
		add_vertex(1, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'h0002_0000);
		add_vertex(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		add_vertex(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		add_vertex(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
		add_vertex(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h1);
		add_vertex(1, 32'h0005_0000, 32'hFFFB_0000, 32'h7, 32'hFFFD_0000);
		add_vertex(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_vertex(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_vertex(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
		// directed: full-scale matrix drives the dot products into saturation
		for (int i = 0; i < 8; i++) write_reg(i, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
		add_vertex(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_vertex(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_vertex(1, 32'h1, 32'h0, 32'h0, 32'h0);
		add_vertex(1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
		drain();
		for (int i = 0; i < 8; i++) write_reg(i, {32'h8000_0000, 32'h8000_0000});
		add_vertex(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_vertex(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_vertex(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		drain();

		// random phases, each with its own matrix and stall mode
		for (int ph = 0; ph < 8; ph++) begin
			flavor = ph % 6;
			for (int i = 0; i < 8; i++) begin
				if (flavor >= 4 && $urandom_range(1, 0))
					write_reg(i, {pick_entry(5), pick_entry(5)});
				else
					write_reg(i, {pick_entry(flavor), pick_entry(flavor)});
			end
			stall_mode = ph % 4;
			for (int n = 0; n < 55; n++)
				add_vertex($urandom_range(3, 0) != 0, pick_coord(), pick_coord(),
				           pick_coord(), pick_coord());
			drain();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/core/vtp_pkg.sv
rtl/core/vtp_front.sv
rtl/core/vtp_queue.sv
rtl/core/vtp_div.sv
rtl/core/vertex_transform_project.sv
rtl/core/vtp_checker.sv
test/vertex_transform_project_test.sv
